// ===== rtl/integer_to_ascii_formatter_core_defines.svh =====
// Assertion macros for the integer-to-ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define ITOA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa formatter check failed");

// Antecedent implies consequent in the next cycle.
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa formatter check failed");

`else

`define ITOA_ASSERT_SAME(label, clk, rst, ante, cons)
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/itoa_fmt_pkg.sv =====
// Types, codes and character tables shared by the formatter modules.
package itoa_fmt_pkg;

  localparam logic [7:0] CMD_BIN = 8'd98;
  localparam logic [7:0] CMD_HEX = 8'd104;
  localparam logic [7:0] CMD_HEXP = 8'd120;
  localparam logic [7:0] CMD_DEC = 8'd100;
  localparam logic [7:0] CMD_UNS = 8'd117;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h27;

  localparam int UNK_HEAD_LEN = 17;
  localparam logic [4:0] UNK_CMD_POS = 5'(UNK_HEAD_LEN);
  localparam logic [4:0] UNK_LAST_POS = 5'(UNK_HEAD_LEN + 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN,
    ST_XPRE,
    ST_HEX,
    ST_DEC,
    ST_UNK
  } state_t;

  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } sub_res_t;

  function automatic logic [31:0] pow10(input logic [3:0] idx);
    logic [31:0] p;
    case (idx)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = CH_ZERO + {4'd0, nib};
    if (nib > 4'd9) begin
      c = c + HEX_ALPHA_OFS;
    end
    return c;
  endfunction

  // Fixed head of the unknown-format message.
  function automatic logic [7:0] unk_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd2:    c = "u";
      5'd3:    c = "n";
      5'd4:    c = "k";
      5'd5:    c = "n";
      5'd6:    c = "o";
      5'd7:    c = "w";
      5'd8:    c = "n";
      5'd10:   c = "f";
      5'd11:   c = "o";
      5'd12:   c = "r";
      5'd13:   c = "m";
      5'd14:   c = "a";
      5'd15:   c = "t";
      default: c = CH_UNDER;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/itoa_fmt_sub_unit.sv =====
// Shared compare-and-subtract unit for decimal digit extraction.
module itoa_fmt_sub_unit (
  input  logic [31:0]           rem,
  input  logic [3:0]            pow_idx,
  output itoa_fmt_pkg::sub_res_t res
);
  import itoa_fmt_pkg::*;

  logic [32:0] diff_full;

  assign diff_full = {1'b0, rem} - {1'b0, pow10(pow_idx)};
  assign res.ge = ~diff_full[32];
  assign res.diff = diff_full[31:0];

endmodule

// ===== rtl/integer_to_ascii_formatter_core.sv =====
// Top level of the integer-to-ASCII formatter: sequencer and output register.
`include "integer_to_ascii_formatter_core_defines.svh"

// One command formats one 32-bit value into a run of ASCII characters on
// out_char, one per strobe cycle, with last on the final character. The
// receiver cannot stall: every character is shown for exactly one cycle.
// A command is taken when start is high and busy is low; busy stays high
// until the final character appears. Decimal ('u', 'd') digits come from
// the single shared compare-and-subtract unit: each power of ten is
// subtracted from the remainder while it fits, and the count of
// subtractions is the digit for that position. The '-' of a negative 'd'
// value leaves in the cycle right after the transfer, while the first
// digit is still being worked out.
module integer_to_ascii_formatter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] command,
  input  logic [31:0] value,
  output logic       strobe,
  output logic [7:0] out_char,
  output logic       last
);
  import itoa_fmt_pkg::*;

  state_t      state, state_next;
  logic [31:0] rem, rem_next;
  logic [4:0]  idx, idx_next;
  logic [3:0]  q, q_next;
  logic        seen, seen_next;
  logic [7:0]  cmd, cmd_next;
  logic        strobe_next;
  logic [7:0]  out_char_next;
  logic        last_next;
  sub_res_t    sub_res;
  logic        accept;
  logic        pos_last;

  itoa_fmt_sub_unit u_sub (
    .rem     (rem),
    .pow_idx (idx[3:0]),
    .res     (sub_res)
  );

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      last   <= last_next;
    end
    rem      <= rem_next;
    idx      <= idx_next;
    q        <= q_next;
    seen     <= seen_next;
    cmd      <= cmd_next;
    out_char <= out_char_next;
  end

  always_comb begin
    state_next    = state;
    rem_next      = rem;
    idx_next      = idx;
    q_next        = q;
    seen_next     = seen;
    cmd_next      = cmd;
    strobe_next   = 1'b0;
    out_char_next = out_char;
    last_next     = 1'b0;
    pos_last      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rem_next  = value;
          idx_next  = 5'd0;
          q_next    = 4'd0;
          seen_next = 1'b0;
          cmd_next  = command;
          case (command)
            CMD_BIN: state_next = ST_BIN;
            CMD_HEX: state_next = ST_HEX;
            CMD_HEXP: begin
              strobe_next   = 1'b1;
              out_char_next = CH_ZERO;
              state_next    = ST_XPRE;
            end
            CMD_UNS: state_next = ST_DEC;
            CMD_DEC: begin
              state_next = ST_DEC;
              if (value[31]) begin
                strobe_next   = 1'b1;
                out_char_next = CH_MINUS;
                rem_next      = ~value + 32'd1;
              end
            end
            default: state_next = ST_UNK;
          endcase
        end
      end

      ST_BIN: begin
        pos_last      = (idx == 5'd31);
        strobe_next   = 1'b1;
        out_char_next = rem[31] ? CH_ONE : CH_ZERO;
        last_next     = pos_last;
        rem_next      = {rem[30:0], 1'b0};
        idx_next      = idx + 5'd1;
        if (pos_last) begin
          state_next = ST_IDLE;
        end
      end

      ST_XPRE: begin
        strobe_next   = 1'b1;
        out_char_next = CH_X;
        state_next    = ST_HEX;
      end

      ST_HEX: begin
        // Drop leading zero nibbles; the final nibble always shows.
        pos_last      = (idx == 5'd7);
        strobe_next   = seen || (rem[31:28] != 4'd0) || pos_last;
        out_char_next = hex_char(rem[31:28]);
        last_next     = pos_last;
        seen_next     = seen || (rem[31:28] != 4'd0);
        rem_next      = {rem[27:0], 4'd0};
        idx_next      = idx + 5'd1;
        if (pos_last) begin
          state_next = ST_IDLE;
        end
      end

      ST_DEC: begin
        if (sub_res.ge) begin
          rem_next = sub_res.diff;
          q_next   = q + 4'd1;
        end else begin
          // Digit settled: show it unless it is a leading zero.
          pos_last      = (idx == 5'd9);
          strobe_next   = seen || (q != 4'd0) || pos_last;
          out_char_next = CH_ZERO + {4'd0, q};
          last_next     = pos_last;
          seen_next     = seen || (q != 4'd0);
          q_next        = 4'd0;
          idx_next      = idx + 5'd1;
          if (pos_last) begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_UNK: begin
        pos_last      = (idx == UNK_LAST_POS);
        strobe_next   = 1'b1;
        out_char_next = (idx == UNK_CMD_POS) ? cmd : unk_char(idx);
        last_next     = pos_last;
        idx_next      = idx + 5'd1;
        if (pos_last) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  `ITOA_ASSERT_SAME(a_last_frees, clk, rst, strobe && last, !busy)
  `ITOA_ASSERT_SAME(a_mid_busy, clk, rst, strobe && !last, busy)
  `ITOA_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the integer-to-ASCII formatter core.
`timescale 1ns / 1ps

module tb;
  import itoa_fmt_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  command;
  logic [31:0] value;
  logic        strobe;
  logic [7:0]  out_char;
  logic        last;

  char_beat_t  pending_chars[$];
  int          char_errors;
  int          idle_pct;

  integer_to_ascii_formatter_core DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .value    (value),
    .strobe   (strobe),
    .out_char (out_char),
    .last     (last)
  );

  always #6 clk = ~clk;

  // Build the character run that one command should produce.
  function automatic void format_value(input logic [7:0] cmd, input logic [31:0] val);
    logic [7:0]  run[$];
    logic [31:0] mag;
    logic [31:0] weight;
    logic [31:0] digit;
    logic [3:0]  nib;
    logic        seen;
    string       head;
    head = {"__unknown", "_format_"};
    seen = 1'b0;
    mag  = val;
    if (cmd == CMD_BIN) begin
      for (int i = 31; i >= 0; i--) begin
        run.push_back(val[i] ? CH_ONE : CH_ZERO);
      end
    end else if (cmd == CMD_HEX || cmd == CMD_HEXP) begin
      if (cmd == CMD_HEXP) begin
        run.push_back(CH_ZERO);
        run.push_back(CH_X);
      end
      if (val == 32'd0) begin
        run.push_back(CH_ZERO);
      end else begin
        for (int i = 7; i >= 0; i--) begin
          nib = val[i*4 +: 4];
          if (nib != 4'd0) seen = 1'b1;
          if (seen) begin
            run.push_back(nib > 4'd9 ? CH_ZERO + HEX_ALPHA_OFS + 8'(nib) : CH_ZERO + 8'(nib));
          end
        end
      end
    end else if (cmd == CMD_DEC || cmd == CMD_UNS) begin
      if (cmd == CMD_DEC && val[31]) begin
        run.push_back(CH_MINUS);
        mag = ~val + 32'd1;
      end
      if (mag == 32'd0) begin
        run.push_back(CH_ZERO);
      end else begin
        weight = 32'd1000000000;
        for (int k = 0; k < 10; k++) begin
          digit = mag / weight;
          mag   = mag % weight;
          if (digit != 32'd0) seen = 1'b1;
          if (seen) run.push_back(CH_ZERO + digit[7:0]);
          weight = weight / 32'd10;
        end
      end
    end else begin
      for (int i = 0; i < head.len(); i++) begin
        run.push_back(8'(head[i]));
      end
      run.push_back(cmd);
      run.push_back(CH_UNDER);
      run.push_back(CH_UNDER);
    end
    for (int i = 0; i < run.size(); i++) begin
      pending_chars.push_back('{ch: run[i], last: (i == run.size() - 1)});
    end
  endfunction

  // Operands biased toward digit boundaries and the sign bit.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    logic [31:0] p;
    int          e;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 15);
      2: begin
        e = $urandom_range(0, 9);
        p = 32'd1;
        for (int i = 0; i < e; i++) p = p * 32'd10;
        v = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      3: v = 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd1;
      4: v = 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
      default: v = 32'd1 << $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  task automatic flag_error(input string msg);
    char_errors++;
    if (char_errors <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // Hold start through the transfer until busy falls, then drop it for idle cycles at random.
  task automatic send_item(input logic [7:0] cmd, input logic [31:0] val);
    start   <= 1'b1;
    command <= cmd;
    value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    format_value(cmd, val);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : char_check
    char_beat_t want;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        flag_error($sformatf("unexpected char %h last %b", out_char, last));
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || last !== want.last) begin
          flag_error($sformatf("char exp %h/%b got %h/%b",
                               want.ch, want.last, out_char, last));
        end
      end
    end
  end

  task automatic test_binary();
    send_item(CMD_BIN, 32'h0000_0000);
    send_item(CMD_BIN, 32'hFFFF_FFFF);
    send_item(CMD_BIN, 32'h8000_0001);
  endtask

  task automatic test_hex();
    send_item(CMD_HEX, 32'h0000_0000);
    send_item(CMD_HEX, 32'hFFFF_FFFF);
    send_item(CMD_HEX, 32'h00C0_FFEE);
  endtask

  task automatic test_hex_prefixed();
    send_item(CMD_HEXP, 32'h0000_0000);
    send_item(CMD_HEXP, 32'hDEAD_BEEF);
  endtask

  task automatic test_unsigned();
    send_item(CMD_UNS, 32'd0);
    send_item(CMD_UNS, 32'hFFFF_FFFF);
    send_item(CMD_UNS, 32'd1000000000);
    send_item(CMD_UNS, 32'd9);
  endtask

  task automatic test_signed();
    send_item(CMD_DEC, 32'd0);
    send_item(CMD_DEC, 32'h8000_0000);
    send_item(CMD_DEC, 32'hFFFF_FFFF);
    send_item(CMD_DEC, 32'h7FFF_FFFF);
    send_item(CMD_DEC, 32'd12345);
  endtask

  task automatic test_unknown();
    send_item(8'h00, $urandom);
    send_item(8'hFF, $urandom);
    send_item(8'h41, $urandom);
  endtask

  task automatic test_random(input int count, input int pct);
    logic [7:0] cmd;
    idle_pct = pct;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       cmd = CMD_BIN;
        1, 8:    cmd = CMD_HEX;
        2:       cmd = CMD_HEXP;
        3, 4, 9: cmd = CMD_DEC;
        5, 6:    cmd = CMD_UNS;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      send_item(cmd, pick_operand());
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    command     = 8'd0;
    value       = 32'd0;
    char_errors = 0;
    idle_pct    = 30;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_binary();
    test_hex();
    test_hex_prefixed();
    test_unsigned();
    test_signed();
    test_unknown();
    test_random(23, 0);
    test_random(23, 45);
    test_random(22, 0);
    test_random(22, 37);

    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (char_errors == 0 && pending_chars.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
